// File: hdl/wsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the work-stealing deque.
package wsd_pkg;

   localparam int ELEMENT_BITS = 32;
   localparam int OCC_BITS     = 11;

   // Result queue between the front and the back end
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_STEAL = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic [ELEMENT_BITS-1:0] value_type;
   typedef logic [OCC_BITS-1:0]     occ_type;

   // Everything about one result except the value read from the store
   typedef struct packed {
      status_type status;
      occ_type    occupancy;
      logic       take;
   } desc_type;

endpackage

// File: hdl/work_stealing_deque.sv
`timescale 1ns / 1ps
// Work-stealing deque: bounded double-ended work queue over one store.
//
// Commands arrive on the req_ channel (req_command, req_element) and each
// gives exactly one transaction on the rsp_ channel (status, taken value,
// occupancy after the command). Push appends at the bottom, pop removes the
// newest entry from the bottom, steal removes the oldest from the top.
// A transaction moves on either channel at an edge where valid is high and
// stall is low.
// Results pass from the front-end stage and store read through the result
// queue to the output register. Throughput: one command per cycle while
// req_stall is low; one store read or write per command on the single port.
// The front end updates the indices at acceptance; the store read returns
// in the next cycle into a four-entry result queue, which the back end
// drains into the output register.
// When the receiver stalls, up to four results wait in the queue besides
// the one in the output register; then req_stall rises until space frees.
// Reset empties the deque (both indices and the count to zero) and the
// queue; the store contents are not cleared and need no clearing pass.
module work_stealing_deque #(
   parameter int DEPTH      = 1024,
   parameter int ENTRY_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_command,
   input  logic [wsd_pkg::ELEMENT_BITS-1:0]   req_element,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [wsd_pkg::ELEMENT_BITS-1:0]   rsp_taken_value,
   output logic [wsd_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   // Store access from the front end
   logic                          ram_en;
   logic                          ram_we;
   logic [$clog2(DEPTH)-1:0]      ram_addr;
   logic [ENTRY_BITS-1:0]         ram_wdata;
   logic [ENTRY_BITS-1:0]         ram_rdata;

   // Result queue links
   logic                              q_push;
   wsd_pkg::desc_type                 q_desc;
   logic [wsd_pkg::Q_CNT_BITS-1:0]    q_count;
   logic                              q_pop;
   logic                              q_head_valid;
   wsd_pkg::desc_type                 q_head_desc;
   logic [ENTRY_BITS-1:0]             q_head_data;

   wsd_front #(
      .DEPTH      (DEPTH),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_element (req_element),
      .q_count     (q_count),
      .ram_en      (ram_en),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .q_push      (q_push),
      .q_desc      (q_desc)
   );

   // Entry store: written by push, read by pop and steal
   wsd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Read data joins its descriptor as both enter the queue
   wsd_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .push_data  (ram_rdata),
      .pop        (q_pop),
      .count      (q_count),
      .head_valid (q_head_valid),
      .head_desc  (q_head_desc),
      .head_data  (q_head_data)
   );

   wsd_back #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_desc       (q_head_desc),
      .head_data       (q_head_data),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_occupancy   (rsp_occupancy)
   );

endmodule

// File: hdl/wsd_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module wsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/wsd_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, keeps the indices and issues store accesses.
module wsd_front #(
   parameter int DEPTH      = 1024,
   parameter int ENTRY_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [wsd_pkg::ELEMENT_BITS-1:0]    req_element,
   input  logic [wsd_pkg::Q_CNT_BITS-1:0]      q_count,
   output logic                                ram_en,
   output logic                                ram_we,
   output logic [$clog2(DEPTH)-1:0]            ram_addr,
   output logic [ENTRY_BITS-1:0]               ram_wdata,
   output logic                                q_push,
   output wsd_pkg::desc_type                   q_desc
);

   localparam int SW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [SW-1:0] top_ff, top_in;
   logic [SW-1:0] bottom_ff, bottom_in;
   logic [CW-1:0] count_ff, count_in;
   logic          s1_valid_ff, s1_valid_in;
   wsd_pkg::desc_type s1_desc_ff, s1_desc_in;

   logic [SW-1:0] top_inc, bottom_inc, bottom_dec;
   logic          full, empty, accept;

   assign top_inc    = (top_ff == SW'(DEPTH - 1)) ? '0 : top_ff + SW'(1);
   assign bottom_inc = (bottom_ff == SW'(DEPTH - 1)) ? '0 : bottom_ff + SW'(1);
   assign bottom_dec = (bottom_ff == '0) ? SW'(DEPTH - 1) : bottom_ff - SW'(1);
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);

   // Hold off while the queue could not absorb one more result
   assign req_stall = ((q_count + wsd_pkg::Q_CNT_BITS'(s1_valid_ff))
                       >= wsd_pkg::Q_CNT_BITS'(wsd_pkg::Q_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      top_in               = top_ff;
      bottom_in            = bottom_ff;
      count_in             = count_ff;
      ram_en               = 1'b0;
      ram_we               = 1'b0;
      ram_addr             = bottom_ff;
      ram_wdata            = ENTRY_BITS'(req_element);
      s1_desc_in.status    = wsd_pkg::STATUS_OK;
      s1_desc_in.take      = 1'b0;
      if (accept) begin
         unique case (req_command)
            wsd_pkg::CMD_PUSH: begin
               if (full) begin
                  s1_desc_in.status = wsd_pkg::STATUS_FULL;
               end else begin
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  bottom_in = bottom_inc;
                  count_in  = count_ff + CW'(1);
               end
            end
            wsd_pkg::CMD_POP: begin
               if (empty) begin
                  s1_desc_in.status = wsd_pkg::STATUS_EMPTY;
               end else begin
                  ram_en          = 1'b1;
                  ram_addr        = bottom_dec;
                  bottom_in       = bottom_dec;
                  count_in        = count_ff - CW'(1);
                  s1_desc_in.take = 1'b1;
               end
            end
            wsd_pkg::CMD_STEAL: begin
               if (empty) begin
                  s1_desc_in.status = wsd_pkg::STATUS_EMPTY;
               end else begin
                  ram_en          = 1'b1;
                  ram_addr        = top_ff;
                  top_in          = top_inc;
                  count_in        = count_ff - CW'(1);
                  s1_desc_in.take = 1'b1;
               end
            end
            default: begin
               // unused code: leave everything as it is
            end
         endcase
      end
      s1_desc_in.occupancy = wsd_pkg::occ_type'(count_in);
      s1_valid_in          = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff      <= '0;
         bottom_ff   <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         top_ff      <= top_in;
         bottom_ff   <= bottom_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_desc_ff <= s1_desc_in;
   end

   // The store's read data lines up with this stage
   assign q_push = s1_valid_ff;
   assign q_desc = s1_desc_ff;

endmodule

// File: hdl/wsd_queue.sv
`timescale 1ns / 1ps
// Short result queue between the front and the back end.
module wsd_queue #(
   parameter int DATA_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  wsd_pkg::desc_type                  push_desc,
   input  logic [DATA_BITS-1:0]               push_data,
   input  logic                               pop,
   output logic [wsd_pkg::Q_CNT_BITS-1:0]     count,
   output logic                               head_valid,
   output wsd_pkg::desc_type                  head_desc,
   output logic [DATA_BITS-1:0]               head_data
);

   wsd_pkg::desc_type                 desc_ff [wsd_pkg::Q_DEPTH];
   logic [DATA_BITS-1:0]              data_ff [wsd_pkg::Q_DEPTH];
   logic [wsd_pkg::Q_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wsd_pkg::Q_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wsd_pkg::Q_CNT_BITS-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + wsd_pkg::Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + wsd_pkg::Q_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + wsd_pkg::Q_CNT_BITS'(push) - wsd_pkg::Q_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         desc_ff[wr_ptr_ff] <= push_desc;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count      = count_ff;
   assign head_valid = (count_ff != '0);
   assign head_desc  = desc_ff[rd_ptr_ff];
   assign head_data  = data_ff[rd_ptr_ff];

endmodule

// File: hdl/wsd_back.sv
`timescale 1ns / 1ps
// Back end: forms each result and holds it in the output register.
module wsd_back #(
   parameter int ENTRY_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  wsd_pkg::desc_type                  head_desc,
   input  logic [ENTRY_BITS-1:0]              head_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [wsd_pkg::ELEMENT_BITS-1:0]   rsp_taken_value,
   output logic [wsd_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   logic                  valid_ff, valid_in;
   wsd_pkg::status_type   status_ff;
   wsd_pkg::value_type    taken_ff, taken_in;
   wsd_pkg::occ_type      occ_ff;

   // Advance when the output register is free or being emptied
   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign taken_in = head_desc.take ? wsd_pkg::value_type'(head_data) : '0;

   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         status_ff <= head_desc.status;
         taken_ff  <= taken_in;
         occ_ff    <= head_desc.occupancy;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_taken_value = taken_ff;
   assign rsp_occupancy   = occ_ff;

endmodule

// File: verif/wsd_checker.sv
`timescale 1ns / 1ps
// Watches the deque's command and result channels, predicts each result and compares.
module wsd_checker #(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_command,
   input  wsd_pkg::value_type        req_element,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_status,
   input  wsd_pkg::value_type        rsp_taken_value,
   input  wsd_pkg::occ_type          rsp_occupancy,
   output int                        mismatches,
   output int unsigned               outstanding
);

   localparam int IDX_BITS = $clog2(2 * DEPTH);

   typedef struct packed {
      wsd_pkg::status_type status;
      wsd_pkg::value_type  taken;
      wsd_pkg::occ_type    occupancy;
   } outcome_type;

   wsd_pkg::value_type     deque_slots [DEPTH];
   logic [IDX_BITS-1:0]    steal_idx;
   logic [IDX_BITS-1:0]    owner_idx;
   outcome_type            owed_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      steal_idx   = '0;
      owner_idx   = '0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Apply one command to the shadow deque and queue the result it owes.
   task automatic apply_command(input logic [1:0] cmd, input wsd_pkg::value_type elem);
      outcome_type      res;
      wsd_pkg::occ_type held;
      held       = wsd_pkg::occ_type'(owner_idx - steal_idx);
      res.status = wsd_pkg::STATUS_OK;
      res.taken  = '0;
      case (cmd)
         wsd_pkg::CMD_PUSH: begin
            if (held >= DEPTH) begin
               res.status = wsd_pkg::STATUS_FULL;
            end else begin
               deque_slots[owner_idx % DEPTH] = elem;
               owner_idx = owner_idx + 1'b1;
            end
         end
         wsd_pkg::CMD_POP: begin
            if (held == 0) begin
               res.status = wsd_pkg::STATUS_EMPTY;
            end else begin
               owner_idx = owner_idx - 1'b1;
               res.taken = deque_slots[owner_idx % DEPTH];
            end
         end
         wsd_pkg::CMD_STEAL: begin
            if (held == 0) begin
               res.status = wsd_pkg::STATUS_EMPTY;
            end else begin
               res.taken = deque_slots[steal_idx % DEPTH];
               steal_idx = steal_idx + 1'b1;
            end
         end
         default: ;
      endcase
      res.occupancy = wsd_pkg::occ_type'(owner_idx - steal_idx);
      owed_results.push_back(res);
   endtask

   task automatic check_result();
      outcome_type want;
      if (owed_results.size() == 0) begin
         report_mismatch("result with nothing owed, status", rsp_status, '0);
      end else begin
         want = owed_results.pop_front();
         if (rsp_status !== want.status)
            report_mismatch("status", rsp_status, want.status);
         if (rsp_taken_value !== want.taken)
            report_mismatch("taken value", rsp_taken_value, want.taken);
         if (rsp_occupancy !== want.occupancy)
            report_mismatch("occupancy", rsp_occupancy, want.occupancy);
      end
   endtask

   // Results are compared before the command of the same edge is applied.
   always @(posedge clock) begin
      if (reset) begin
         steal_idx = '0;
         owner_idx = '0;
         owed_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            apply_command(req_command, req_element);
      end
      outstanding = owed_results.size();
   end

endmodule

// File: verif/tb_work_stealing_deque.sv
`timescale 1ns / 1ps
// Testbench top of the work-stealing deque: stimulus, idling, watchdog and verdict.
module tb_work_stealing_deque;

   localparam int         DEPTH       = 1024;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;  // spare code, the block must ignore it
   localparam int         LONG_HOLD   = 60;    // receiver hold-off, in cycles
   localparam int         QUIET_LIMIT = 500;   // cycles with no transaction before giving up
   localparam int         TAIL_CYCLES = 8;     // settle time after the last result

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [1:0]          req_command     = wsd_pkg::CMD_PUSH;
   wsd_pkg::value_type  req_element     = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [1:0]          rsp_status;
   wsd_pkg::value_type  rsp_taken_value;
   wsd_pkg::occ_type    rsp_occupancy;

   // Stimulus controls shared with the receiver process
   logic        idling_on       = 1'b1;
   logic        hold_results    = 1'b0;

   int          mismatches;
   int unsigned outstanding;
   int unsigned quiet_cycles    = 0;

   work_stealing_deque #(
      .DEPTH      (DEPTH),
      .ENTRY_BITS (wsd_pkg::ELEMENT_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_occupancy   (rsp_occupancy)
   );

   // The checker sits beside the block, predicting and comparing every result;
   // the top only sees how many results are still owed and how many went wrong.
   wsd_checker #(
      .DEPTH (DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_element     (req_element),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_taken_value (rsp_taken_value),
      .rsp_occupancy   (rsp_occupancy),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: count cycles in which neither channel moves a transaction and
   // end the run once the count reaches the limit. A lost or extra owed result
   // leaves the final drain waiting forever, so it ends up here as well.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stall in random bursts while idling is on, and hold off for
   // one long stretch on request so that the result queue fills and the
   // block has to stall its command input. Drive only at falling edges,
   // and never twice in one step: every branch waits a falling edge first.
   initial begin : receiver
      int unsigned burst;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_results = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one command and hold it until the block takes it. Enter and leave
   // at a falling edge with nothing yet assigned in that step, so valid is
   // never lowered and raised again within one step.
   task automatic send_cmd(input logic [1:0] cmd, input wsd_pkg::value_type elem);
      int unsigned gap;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_element <= elem;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // Weight pushes against pops and steals; the spare code turns up now and then.
   function automatic logic [1:0] pick_command(input int unsigned push_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll == 99)
         return CMD_UNUSED;
      if (roll < push_pct)
         return wsd_pkg::CMD_PUSH;
      return $urandom_range(0, 1) ? wsd_pkg::CMD_POP : wsd_pkg::CMD_STEAL;
   endfunction

   // Mostly random values, with the all-zero and all-one extremes mixed in.
   function automatic wsd_pkg::value_type pick_element();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return wsd_pkg::value_type'($urandom);
      endcase
   endfunction

   task automatic run_phase(input int unsigned count, input int unsigned push_pct);
      repeat (count) send_cmd(pick_command(push_pct), pick_element());
   endtask

   initial begin : stimulus
      // Hold reset from the start, release it at a falling edge.
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty deque, extremes of the element, spare code, and the
      // last entry taken from either end.
      send_cmd(wsd_pkg::CMD_POP,   wsd_pkg::value_type'($urandom));
      send_cmd(wsd_pkg::CMD_STEAL, wsd_pkg::value_type'($urandom));
      send_cmd(CMD_UNUSED,         '0);
      send_cmd(wsd_pkg::CMD_PUSH,  32'h0000_0000);
      send_cmd(wsd_pkg::CMD_PUSH,  32'hFFFF_FFFF);
      send_cmd(wsd_pkg::CMD_PUSH,  32'hA5A5_5A5A);
      send_cmd(CMD_UNUSED,         32'hFFFF_FFFF);
      send_cmd(wsd_pkg::CMD_POP,   '1);
      send_cmd(wsd_pkg::CMD_STEAL, '1);
      send_cmd(wsd_pkg::CMD_STEAL, '0);
      send_cmd(wsd_pkg::CMD_POP,   '0);
      send_cmd(wsd_pkg::CMD_STEAL, '0);
      send_cmd(wsd_pkg::CMD_PUSH,  32'h0000_0001);
      send_cmd(wsd_pkg::CMD_POP,   '0);
      send_cmd(wsd_pkg::CMD_PUSH,  32'h8000_0000);
      send_cmd(wsd_pkg::CMD_STEAL, '0);
      send_cmd(wsd_pkg::CMD_PUSH,  32'h7FFF_FFFF);
      send_cmd(wsd_pkg::CMD_PUSH,  32'h5555_5555);
      send_cmd(wsd_pkg::CMD_POP,   '0);
      send_cmd(wsd_pkg::CMD_POP,   '0);
      send_cmd(wsd_pkg::CMD_POP,   '0);

      // Balanced traffic around the empty end; open with the long receiver
      // hold-off while commands keep coming, so the block backs up.
      hold_results = 1'b1;
      run_phase(24, 55);
      run_phase(106, 55);

      // Pause the sender until everything owed has arrived.
      drain_results();

      // Push-heavy: fill the store, wrap the slots, then keep knocking on the
      // full deque with the odd pop or steal opening a gap.
      run_phase(1150, 98);

      // Drain-heavy, idling off for the last stretch.
      run_phase(50, 10);
      idling_on = 1'b0;
      run_phase(200, 10);

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
